@@ rtl/ckfg_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ckfg_pkg
// Shared types and codes for the checkpoint freshness gate.
// ============================================================================
package ckfg_pkg;

  // default widths of the stored generation and state hash
  localparam int unsigned HASH_BITS_DEF = 64;
  localparam int unsigned GEN_BITS_DEF  = 32;

  // event selector
  typedef enum logic [2:0] {
    ACT_LOAD     = 3'd0,
    ACT_REQUIRE  = 3'd1,
    ACT_BEGIN    = 3'd2,
    ACT_RESPONSE = 3'd3,
    ACT_COMPLETE = 3'd4,
    ACT_ADVANCE  = 3'd5
  } act_t;

  // gate mode
  typedef enum logic [2:0] {
    MODE_REQUIRED = 3'd0,
    MODE_WAITING  = 3'd1,
    MODE_READY    = 3'd2,
    MODE_RESYNC   = 3'd3,
    MODE_FORKED   = 3'd4
  } mode_t;

  // result codes
  typedef enum logic [3:0] {
    RC_OK          = 4'd0,
    RC_NOT_WAITING = 4'd1,
    RC_WRONG_CONV  = 4'd2,
    RC_WRONG_CHAL  = 4'd3,
    RC_WRONG_CKPT  = 4'd4,
    RC_BAD_WITNESS = 4'd5,
    RC_BAD_PROOF   = 4'd6,
    RC_STALE       = 4'd7,
    RC_FORK        = 4'd8,
    RC_RESYNC      = 4'd9,
    RC_REFUSED     = 4'd10
  } rc_t;

  // one input event
  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] conversation_id;
    logic [63:0] nonce;
    logic [63:0] chal_conversation_id;
    logic [31:0] chal_generation;
    logic [63:0] chal_state_hash;
    logic [63:0] new_conversation_id;
    logic [31:0] new_generation;
    logic [63:0] new_state_hash;
    logic [63:0] witness_account_id;
    logic [63:0] witness_client_id;
    logic        proof_verified;
  } in_item_t;

  // one result
  typedef struct packed {
    logic [3:0]  result_code;
    logic [2:0]  gate_state;
    logic        sending_allowed;
    logic [31:0] known_generation;
  } out_item_t;

endpackage

@@ rtl/ckfg_stream_if.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ckfg_stream_if
// Valid/ready channel carrying one payload per transaction.
// ============================================================================
interface ckfg_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/ckfg_eval.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ckfg_eval
// Combinational event evaluation: next gate state and the result item.
// ============================================================================
module ckfg_eval #(
  parameter int unsigned HASH_BITS = ckfg_pkg::HASH_BITS_DEF,
  parameter int unsigned GEN_BITS  = ckfg_pkg::GEN_BITS_DEF
) (
  input  ckfg_pkg::in_item_t  item,
  input  ckfg_pkg::mode_t     mode,
  input  logic [63:0]         known_conv,
  input  logic [GEN_BITS-1:0] known_gen,
  input  logic [HASH_BITS-1:0] known_hash,
  input  logic                chal_valid,
  input  logic [63:0]         chal_nonce,
  input  logic                tgt_valid,
  input  logic [63:0]         tgt_conv,
  input  logic [GEN_BITS-1:0] tgt_gen,
  input  logic [HASH_BITS-1:0] tgt_hash,
  output ckfg_pkg::mode_t     mode_nxt,
  output logic [63:0]         known_conv_nxt,
  output logic [GEN_BITS-1:0] known_gen_nxt,
  output logic [HASH_BITS-1:0] known_hash_nxt,
  output logic                chal_valid_nxt,
  output logic [63:0]         chal_nonce_nxt,
  output logic                tgt_valid_nxt,
  output logic [63:0]         tgt_conv_nxt,
  output logic [GEN_BITS-1:0] tgt_gen_nxt,
  output logic [HASH_BITS-1:0] tgt_hash_nxt,
  output ckfg_pkg::out_item_t result
);

  logic [63:0]          nc;
  logic [GEN_BITS-1:0]  ng;
  logic [HASH_BITS-1:0] nh;
  logic [GEN_BITS-1:0]  cg;
  logic [HASH_BITS-1:0] ch;
  ckfg_pkg::rc_t        rc;

  // generation and hash fields cut or widened to the stored widths
  assign nc = item.new_conversation_id;
  assign ng = GEN_BITS'(item.new_generation);
  assign nh = HASH_BITS'(item.new_state_hash);
  assign cg = GEN_BITS'(item.chal_generation);
  assign ch = HASH_BITS'(item.chal_state_hash);

  // event decode and state update
  always_comb begin
    mode_nxt       = mode;
    known_conv_nxt = known_conv;
    known_gen_nxt  = known_gen;
    known_hash_nxt = known_hash;
    chal_valid_nxt = chal_valid;
    chal_nonce_nxt = chal_nonce;
    tgt_valid_nxt  = tgt_valid;
    tgt_conv_nxt   = tgt_conv;
    tgt_gen_nxt    = tgt_gen;
    tgt_hash_nxt   = tgt_hash;
    rc             = ckfg_pkg::RC_REFUSED;

    case (item.action)
      ckfg_pkg::ACT_LOAD, ckfg_pkg::ACT_REQUIRE: begin
        known_conv_nxt = nc;
        known_gen_nxt  = ng;
        known_hash_nxt = nh;
        chal_valid_nxt = 1'b0;
        chal_nonce_nxt = '0;
        tgt_valid_nxt  = 1'b0;
        tgt_conv_nxt   = '0;
        tgt_gen_nxt    = '0;
        tgt_hash_nxt   = '0;
        mode_nxt       = (item.action == ckfg_pkg::ACT_LOAD) ?
                         ckfg_pkg::MODE_READY : ckfg_pkg::MODE_REQUIRED;
        rc             = ckfg_pkg::RC_OK;
      end
      ckfg_pkg::ACT_BEGIN: begin
        if (item.nonce != '0 && known_conv != '0 && known_hash != '0 &&
            mode != ckfg_pkg::MODE_FORKED) begin
          chal_valid_nxt = 1'b1;
          chal_nonce_nxt = item.nonce;
          tgt_valid_nxt  = 1'b0;
          tgt_conv_nxt   = '0;
          tgt_gen_nxt    = '0;
          tgt_hash_nxt   = '0;
          mode_nxt       = ckfg_pkg::MODE_WAITING;
          rc             = ckfg_pkg::RC_OK;
        end
      end
      ckfg_pkg::ACT_RESPONSE: begin
        // checks in priority order
        if (mode != ckfg_pkg::MODE_WAITING || !chal_valid) begin
          rc = ckfg_pkg::RC_NOT_WAITING;
        end else if (item.conversation_id != known_conv ||
                     item.chal_conversation_id != known_conv ||
                     nc != known_conv) begin
          rc = ckfg_pkg::RC_WRONG_CONV;
        end else if (item.nonce != chal_nonce) begin
          rc = ckfg_pkg::RC_WRONG_CHAL;
        end else if (cg != known_gen || ch != known_hash) begin
          rc = ckfg_pkg::RC_WRONG_CKPT;
        end else if (item.witness_account_id == '0 ||
                     item.witness_client_id == '0) begin
          rc = ckfg_pkg::RC_BAD_WITNESS;
        end else if (nh == '0 || !item.proof_verified) begin
          rc = ckfg_pkg::RC_BAD_PROOF;
        end else if (ng < known_gen) begin
          rc = ckfg_pkg::RC_STALE;
        end else begin
          chal_valid_nxt = 1'b0;
          chal_nonce_nxt = '0;
          if (ng == known_gen) begin
            if (nh != known_hash) begin
              mode_nxt = ckfg_pkg::MODE_FORKED;
              rc       = ckfg_pkg::RC_FORK;
            end else begin
              mode_nxt = ckfg_pkg::MODE_READY;
              rc       = ckfg_pkg::RC_OK;
            end
          end else begin
            // newer checkpoint offered: remember it as resync target
            tgt_valid_nxt = 1'b1;
            tgt_conv_nxt  = nc;
            tgt_gen_nxt   = ng;
            tgt_hash_nxt  = nh;
            mode_nxt      = ckfg_pkg::MODE_RESYNC;
            rc            = ckfg_pkg::RC_RESYNC;
          end
        end
      end
      ckfg_pkg::ACT_COMPLETE: begin
        if (mode == ckfg_pkg::MODE_RESYNC && tgt_valid && nc == tgt_conv &&
            ng == tgt_gen && nh == tgt_hash) begin
          known_conv_nxt = nc;
          known_gen_nxt  = ng;
          known_hash_nxt = nh;
          tgt_valid_nxt  = 1'b0;
          tgt_conv_nxt   = '0;
          tgt_gen_nxt    = '0;
          tgt_hash_nxt   = '0;
          mode_nxt       = ckfg_pkg::MODE_READY;
          rc             = ckfg_pkg::RC_OK;
        end
      end
      ckfg_pkg::ACT_ADVANCE: begin
        if (mode == ckfg_pkg::MODE_READY && nc != '0 && nh != '0 &&
            nc == known_conv && ng >= known_gen &&
            !(ng == known_gen && nh != known_hash)) begin
          known_gen_nxt  = ng;
          known_hash_nxt = nh;
          rc             = ckfg_pkg::RC_OK;
        end
      end
      default: begin
        rc = ckfg_pkg::RC_REFUSED;
      end
    endcase
  end

  // result fields follow the updated state
  assign result.result_code      = rc;
  assign result.gate_state       = mode_nxt;
  assign result.sending_allowed  = (mode_nxt == ckfg_pkg::MODE_READY);
  assign result.known_generation = 32'(known_gen_nxt);

endmodule

@@ rtl/checkpoint_freshness_gate_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// checkpoint_freshness_gate_top
// Witness-challenge gate over a trusted checkpoint; one result per event.
// ============================================================================
//
//   channel  | dir | handshake           | payload
//   ---------+-----+---------------------+---------------------------------
//   in_ch    | in  | valid / ready       | ckfg_pkg::in_item_t (one event)
//   out_ch   | out | valid / ready       | ckfg_pkg::out_item_t (one result)
//
// One event per cycle while the result is not stalled: an event is held in the
// input register, is evaluated against the gate state and lands in the result
// register, from which the result is offered on out_ch until it is taken.
// Reset (rst_n low, synchronous) empties both registers and clears the gate
// to the required mode with a zero checkpoint, no challenge and no target.
// A stalled result holds both stages; input ready drops only when both are full.
module checkpoint_freshness_gate_top #(
  parameter int unsigned HASH_BITS = ckfg_pkg::HASH_BITS_DEF,
  parameter int unsigned GEN_BITS  = ckfg_pkg::GEN_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  ckfg_stream_if.sink   in_ch,
  ckfg_stream_if.source out_ch
);

  // input register
  logic                 s1_valid_r;
  ckfg_pkg::in_item_t   s1_item_r;
  // result register
  logic                 out_valid_r;
  ckfg_pkg::out_item_t  out_item_r;

  // gate state
  ckfg_pkg::mode_t      mode_r, mode_nxt;
  logic [63:0]          known_conv_r, known_conv_nxt;
  logic [GEN_BITS-1:0]  known_gen_r, known_gen_nxt;
  logic [HASH_BITS-1:0] known_hash_r, known_hash_nxt;
  logic                 chal_valid_r, chal_valid_nxt;
  logic [63:0]          chal_nonce_r, chal_nonce_nxt;
  logic                 tgt_valid_r, tgt_valid_nxt;
  logic [63:0]          tgt_conv_r, tgt_conv_nxt;
  logic [GEN_BITS-1:0]  tgt_gen_r, tgt_gen_nxt;
  logic [HASH_BITS-1:0] tgt_hash_r, tgt_hash_nxt;

  ckfg_pkg::out_item_t  result;
  logic                 out_free;
  logic                 s1_adv;
  logic                 in_take;

  // handshake
  assign out_free     = !out_valid_r || out_ch.ready;
  assign s1_adv       = s1_valid_r && out_free;
  assign in_ch.ready  = !s1_valid_r || out_free;
  assign in_take      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

  // event evaluation
  ckfg_eval #(
    .HASH_BITS (HASH_BITS),
    .GEN_BITS  (GEN_BITS)
  ) u_eval (
    .item           (s1_item_r),
    .mode           (mode_r),
    .known_conv     (known_conv_r),
    .known_gen      (known_gen_r),
    .known_hash     (known_hash_r),
    .chal_valid     (chal_valid_r),
    .chal_nonce     (chal_nonce_r),
    .tgt_valid      (tgt_valid_r),
    .tgt_conv       (tgt_conv_r),
    .tgt_gen        (tgt_gen_r),
    .tgt_hash       (tgt_hash_r),
    .mode_nxt       (mode_nxt),
    .known_conv_nxt (known_conv_nxt),
    .known_gen_nxt  (known_gen_nxt),
    .known_hash_nxt (known_hash_nxt),
    .chal_valid_nxt (chal_valid_nxt),
    .chal_nonce_nxt (chal_nonce_nxt),
    .tgt_valid_nxt  (tgt_valid_nxt),
    .tgt_conv_nxt   (tgt_conv_nxt),
    .tgt_gen_nxt    (tgt_gen_nxt),
    .tgt_hash_nxt   (tgt_hash_nxt),
    .result         (result)
  );

  // input register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_ch.data;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_item_r <= result;
    end
  end

  // gate state update, one event per advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= ckfg_pkg::MODE_REQUIRED;
      known_conv_r <= '0;
      known_gen_r  <= '0;
      known_hash_r <= '0;
      chal_valid_r <= 1'b0;
      chal_nonce_r <= '0;
      tgt_valid_r  <= 1'b0;
      tgt_conv_r   <= '0;
      tgt_gen_r    <= '0;
      tgt_hash_r   <= '0;
    end else if (s1_adv) begin
      mode_r       <= mode_nxt;
      known_conv_r <= known_conv_nxt;
      known_gen_r  <= known_gen_nxt;
      known_hash_r <= known_hash_nxt;
      chal_valid_r <= chal_valid_nxt;
      chal_nonce_r <= chal_nonce_nxt;
      tgt_valid_r  <= tgt_valid_nxt;
      tgt_conv_r   <= tgt_conv_nxt;
      tgt_gen_r    <= tgt_gen_nxt;
      tgt_hash_r   <= tgt_hash_nxt;
    end
  end

endmodule
